// ===== sv/stf_pkg.sv =====
`default_nettype none

package stf_pkg;

   localparam int TOKEN_MAX = 16;
   localparam int MAX_INPUT = 65536;
   localparam int WIN_DEPTH = TOKEN_MAX + 2;

   localparam int CHAR_W    = 8;
   localparam int TOK_LEN_W = 5;
   localparam int CFG_W     = 64;
   localparam int POS_W     = 16;
   localparam int LEN_W     = $clog2(TOKEN_MAX + 1);
   localparam int WIN_W     = $clog2(WIN_DEPTH);
   localparam int COUNT_W   = $clog2(MAX_INPUT + 1);
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOKEN_LENGTH = 3'd0,
      CSR_TOKEN_LOW    = 3'd1,
      CSR_TOKEN_HIGH   = 3'd2,
      CSR_SEP_LOW      = 3'd3,
      CSR_SEP_HIGH     = 3'd4
   } csr_index_type;

   typedef logic [CHAR_W-1:0] char_type;

   // ascii upper case folded to lower case
   function automatic char_type fold_char(input char_type c);
      char_type r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   // bytes above 127 never separate
   function automatic logic is_sep(input char_type c, input logic [2*CFG_W-1:0] mask);
      logic r;
      r = 1'b0;
      if (!c[CHAR_W-1]) begin
         r = mask[c[CHAR_W-2:0]];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/stf_if.sv =====
`default_nettype none

interface stf_req_if;
   logic                      valid;
   logic                      ready;
   logic [stf_pkg::CHAR_W-1:0] char_byte;
   logic                      last_char;

   modport source (output valid, output char_byte, output last_char, input ready);
   modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface stf_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     found;
   logic [stf_pkg::POS_W-1:0] match_position;
   logic                     length_exceeded;

   modport source (output valid, output found, output match_position,
                   output length_exceeded, input ready);
   modport sink   (input valid, input found, input match_position,
                   input length_exceeded, output ready);
endinterface

interface stf_csr_if;
   logic                         valid;
   logic                         ready;
   logic [stf_pkg::CSR_IDX_W-1:0] reg_index;
   logic [stf_pkg::CFG_W-1:0]     wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== sv/separated_token_finder_top.sv =====
// path: a byte accepted into the input register is judged from there; the result of a
//   last byte is loaded into the result register once it is free, which drives rsp
// throughput: one byte per cycle, set by the combinational parallel window compare; a
//   last byte waits in the input register while the previous result is unread
// reset: synchronous, active high; clears the stream state, the handshakes and
//   the registers (token length 1, the rest zero); the byte window is not cleared
`default_nettype none

module separated_token_finder_top (
   input  wire         clock,
   input  wire         reset,
   stf_req_if.sink     req_ch,
   stf_rsp_if.source   rsp_ch,
   stf_csr_if.sink     csr_ch
);
   import stf_pkg::*;

   // configuration
   logic [TOK_LEN_W-1:0] tok_len_ff;
   logic [CFG_W-1:0]     tok_low_ff;
   logic [CFG_W-1:0]     tok_high_ff;
   logic [CFG_W-1:0]     sep_low_ff;
   logic [CFG_W-1:0]     sep_high_ff;

   // input register
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   char_type             s1_byte_ff;
   logic                 s1_last_ff;

   // stream state
   char_type             win_ff [WIN_DEPTH-1];
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic                 seen_ff;
   logic                 seen_in;
   logic [POS_W-1:0]     offset_ff;
   logic [POS_W-1:0]     offset_in;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic                 rsp_exc_ff;

   // judging logic
   logic                 out_free;
   logic                 s1_go;
   logic                 in_range;
   logic                 at_end;
   logic [TOK_LEN_W-1:0] len_clamp;
   logic [LEN_W-1:0]     len_eff;
   logic [WIN_W-1:0]     len_w;
   logic [COUNT_W-1:0]   len_c;
   logic [COUNT_W-1:0]   p_next;
   logic [2*CFG_W-1:0]   tok_chars;
   logic [2*CFG_W-1:0]   sep_mask;
   char_type             win_new [WIN_DEPTH];
   char_type             tokf [TOKEN_MAX];
   logic                 eq [TOKEN_MAX+1][TOKEN_MAX];
   logic [WIN_DEPTH-1:0] sepv;
   logic [TOKEN_MAX:0]   cand1_vec;
   logic [TOKEN_MAX:0]   cand0_vec;
   logic                 hit1;
   logic                 hit0;
   logic [COUNT_W-1:0]   off1;
   logic [COUNT_W-1:0]   off0;

   assign tok_chars = {tok_high_ff, tok_low_ff};
   assign sep_mask  = {sep_high_ff, sep_low_ff};

   always_comb begin
      if (tok_len_ff == '0) begin
         len_clamp = TOK_LEN_W'(1);
      end else if (tok_len_ff > TOK_LEN_W'(TOKEN_MAX)) begin
         len_clamp = TOK_LEN_W'(TOKEN_MAX);
      end else begin
         len_clamp = tok_len_ff;
      end
   end

   assign len_eff = LEN_W'(len_clamp);
   assign len_w   = WIN_W'(len_eff);
   assign len_c   = COUNT_W'(len_eff);

   // window as it stands once the current byte is shifted in
   always_comb begin
      win_new[0] = s1_byte_ff;
      for (int w = 1; w < WIN_DEPTH; w++) begin
         win_new[w] = win_ff[w-1];
      end
      for (int i = 0; i < TOKEN_MAX; i++) begin
         tokf[i] = fold_char(tok_chars[CHAR_W*i +: CHAR_W]);
      end
      for (int w = 0; w <= TOKEN_MAX; w++) begin
         for (int i = 0; i < TOKEN_MAX; i++) begin
            eq[w][i] = (fold_char(win_new[w]) == tokf[i]);
         end
      end
      for (int w = 0; w < WIN_DEPTH; w++) begin
         sepv[w] = is_sep(win_new[w], sep_mask);
      end
   end

   // one candidate per token length, fixed window places for each
   always_comb begin
      cand1_vec = '0;
      cand0_vec = '0;
      for (int l = 1; l <= TOKEN_MAX; l++) begin
         cand1_vec[l] = 1'b1;
         cand0_vec[l] = 1'b1;
         for (int i = 0; i < TOKEN_MAX; i++) begin
            if (i < l) begin
               cand1_vec[l] = cand1_vec[l] & eq[l-i][i];
               cand0_vec[l] = cand0_vec[l] & eq[l-1-i][i];
            end
         end
      end
   end

   assign in_range = (count_ff < COUNT_W'(MAX_INPUT));
   assign p_next   = count_ff + COUNT_W'(1);
   assign at_end   = s1_last_ff || (p_next == COUNT_W'(MAX_INPUT));
   assign off1     = count_ff - len_c;
   assign off0     = p_next - len_c;

   // match ending one byte back, bounded by the byte just taken
   assign hit1 = in_range && !seen_ff && (count_ff >= len_c) && cand1_vec[len_eff]
                 && ((count_ff <= len_c) || sepv[len_w + WIN_W'(1)]) && sepv[0];
   // match ending at the final byte of the string
   assign hit0 = in_range && !seen_ff && !hit1 && at_end && (p_next >= len_c)
                 && cand0_vec[len_eff] && ((p_next <= len_c) || sepv[len_w]);

   always_comb begin
      seen_in   = seen_ff | hit1 | hit0;
      offset_in = offset_ff;
      count_in  = count_ff;
      if (hit1) begin
         offset_in = off1[POS_W-1:0];
      end else if (hit0) begin
         offset_in = off0[POS_W-1:0];
      end
      if (in_range) begin
         count_in = p_next;
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go       = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign s1_valid_in = (req_ch.valid && req_ch.ready) || (s1_valid_ff && !s1_go);

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_len_ff   <= TOK_LEN_W'(1);
         tok_low_ff   <= '0;
         tok_high_ff  <= '0;
         sep_low_ff   <= '0;
         sep_high_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_ch.reg_index)
               CSR_TOKEN_LENGTH: tok_len_ff  <= csr_ch.wr_data[TOK_LEN_W-1:0];
               CSR_TOKEN_LOW:    tok_low_ff  <= csr_ch.wr_data;
               CSR_TOKEN_HIGH:   tok_high_ff <= csr_ch.wr_data;
               CSR_SEP_LOW:      sep_low_ff  <= csr_ch.wr_data;
               CSR_SEP_HIGH:     sep_high_ff <= csr_ch.wr_data;
               default: ;
            endcase
         end
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            if (s1_last_ff) begin
               count_ff  <= '0;
               seen_ff   <= 1'b0;
               offset_ff <= '0;
            end else begin
               count_ff  <= count_in;
               seen_ff   <= seen_in;
               offset_ff <= offset_in;
            end
         end
         if (s1_go && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_byte_ff <= req_ch.char_byte;
         s1_last_ff <= req_ch.last_char;
      end
      if (s1_go && in_range) begin
         win_ff[0] <= s1_byte_ff;
         for (int w = 1; w < WIN_DEPTH - 1; w++) begin
            win_ff[w] <= win_ff[w-1];
         end
      end
      if (s1_go && s1_last_ff) begin
         rsp_found_ff <= seen_in;
         rsp_pos_ff   <= seen_in ? offset_in : '0;
         rsp_exc_ff   <= !in_range;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.found           = rsp_found_ff;
   assign rsp_ch.match_position  = rsp_pos_ff;
   assign rsp_ch.length_exceeded = rsp_exc_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_INPUT))
      else $error("byte count beyond the searchable limit");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> count_ff == '0 && !seen_ff && offset_ff == '0)
      else $error("stream state not cleared after the last byte");

   a_pos_zero_when_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_pos_ff == '0)
      else $error("match position set without a match");

   a_result_on_last_only: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(s1_go && s1_last_ff) |=> !rsp_valid_ff)
      else $error("result raised without a last byte");

endmodule

`default_nettype wire
